// File: hdl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Shared constants, sequencer state type and calendar helpers for the
// epoch-seconds to calendar converter.
// ----------------------------------------------------------------------------
package edc_pkg;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned LocalOffset = 3600 * 8;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned SecsPerMin  = 60;
	localparam int unsigned BaseYear    = 1970;

	localparam int unsigned DayQuoBits  = 16;
	localparam int unsigned HourQuoBits = 5;
	localparam int unsigned MinQuoBits  = 6;

	localparam logic [31:0] DayDivInit  = 32'(SecsPerDay  << (DayQuoBits  - 1));
	localparam logic [31:0] HourDivInit = 32'(SecsPerHour << (HourQuoBits - 1));
	localparam logic [31:0] MinDivInit  = 32'(SecsPerMin  << (MinQuoBits  - 1));

	localparam logic [3:0] LastMonth = 4'd11;

	localparam logic [1:0] AddrAddEightHours = 2'd0;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DAY  = 6'b000010,
		ST_YEAR = 6'b000100,
		ST_MON  = 6'b001000,
		ST_HOUR = 6'b010000,
		ST_MIN  = 6'b100000
	} edc_state_t;

	// Years reachable from a 32-bit count are 1970..2106; 2100 is the only
	// century year in that span that is not leap.
	function automatic logic is_leap(input logic [11:0] y);
		is_leap = (y[1:0] == 2'b00) && (y != 12'd2100);
	endfunction

	function automatic logic [8:0] year_len(input logic [11:0] y);
		year_len = is_leap(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: month_len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   month_len = 5'd30;
			4'd1:                                      month_len = leap ? 5'd29 : 5'd28;
			default:                                   month_len = 5'd31;
		endcase
	endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts a 32-bit seconds count since 1970-01-01 00:00:00 to Gregorian
// date and time, optionally in UTC+8.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while one compare-subtract unit is stepped through the conversion: the day
// count, a walk over the years from 1970, a walk over the months, then the
// hour and the minute. The result appears for one cycle with done high, in the
// first cycle with busy low again, and is not held: the receiver must take it
// then. add_eight_hours (register 0, reset 1) is to be written only while
// idle; the block itself does not enforce this.
module epoch_seconds_to_calendar_top
	import edc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic add_eight_hours;

	edc_apb u_apb (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.add_eight_hours (add_eight_hours)
	);

	edc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.epoch_seconds   (epoch_seconds),
		.add_eight_hours (add_eight_hours),
		.busy            (busy),
		.done            (done),
		.year            (year),
		.month           (month),
		.day_of_month    (day_of_month),
		.hour            (hour),
		.minute          (minute),
		.second          (second)
	);

endmodule

// File: hdl/edc_csub.sv
// ----------------------------------------------------------------------------
// edc_csub
// Shared 32-bit compare-and-subtract unit used by every sequencer step.
// ----------------------------------------------------------------------------
module edc_csub (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] diff,
	output logic        ge
);

	logic [32:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[31:0];
	assign ge   = ~wide[32];

endmodule

// File: hdl/edc_apb.sv
// ----------------------------------------------------------------------------
// edc_apb
// APB-style configuration register holding the add-eight-hours control.
// ----------------------------------------------------------------------------
module edc_apb
	import edc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        add_eight_hours
);

	logic add_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == AddrAddEightHours) begin
			add_q <= pwdata[0];
		end
	end

	assign prdata          = (paddr == AddrAddEightHours) ? {31'd0, add_q} : 32'd0;
	assign pready          = 1'b1;
	assign add_eight_hours = add_q;

endmodule

// File: hdl/edc_core.sv
// ----------------------------------------------------------------------------
// edc_core
// Sequencer driving the shared compare-subtract unit: day division, year
// walk, month walk, then hour and minute division of the seconds left.
// ----------------------------------------------------------------------------
module edc_core
	import edc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] epoch_seconds,
	input  logic        add_eight_hours,
	output logic        busy,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	edc_state_t  state_q;
	logic [3:0]  cnt_q;
	logic [31:0] work_q;
	logic [31:0] div_q;
	logic [15:0] quo_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic [4:0]  hour_q;
	logic        done_q;
	logic [11:0] res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic [4:0]  res_hour_q;
	logic [5:0]  res_minute_q;
	logic [5:0]  res_second_q;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] diff;
	logic        ge;
	logic [15:0] quo_next;
	logic [31:0] work_next;

	always_comb begin
		op_a = work_q;
		op_b = div_q;
		case (state_q)
			ST_YEAR: begin
				op_a = {16'd0, days_q};
				op_b = {23'd0, year_len(year_q)};
			end
			ST_MON: begin
				op_a = {16'd0, days_q};
				op_b = {27'd0, month_len(mon_q, is_leap(year_q))};
			end
			default: begin
				op_a = work_q;
				op_b = div_q;
			end
		endcase
	end

	edc_csub u_csub (
		.a    (op_a),
		.b    (op_b),
		.diff (diff),
		.ge   (ge)
	);

	assign quo_next  = {quo_q[14:0], ge};
	assign work_next = ge ? diff : work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MIN) && (cnt_q == 4'd0);
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_DAY;
				ST_DAY:  if (cnt_q == 4'd0) state_q <= ST_YEAR;
				ST_YEAR: if (!ge) state_q <= ST_MON;
				ST_MON:  if (!ge || mon_q == LastMonth) state_q <= ST_HOUR;
				ST_HOUR: if (cnt_q == 4'd0) state_q <= ST_MIN;
				ST_MIN:  if (cnt_q == 4'd0) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					work_q <= epoch_seconds + (add_eight_hours ? 32'(LocalOffset) : 32'd0);
					div_q  <= DayDivInit;
					cnt_q  <= 4'(DayQuoBits - 1);
					quo_q  <= 16'd0;
				end
			end
			ST_DAY: begin
				work_q <= work_next;
				quo_q  <= quo_next;
				div_q  <= div_q >> 1;
				cnt_q  <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					days_q <= quo_next;
					year_q <= 12'(BaseYear);
				end
			end
			ST_YEAR: begin
				if (ge) begin
					days_q <= diff[15:0];
					year_q <= year_q + 12'd1;
				end else begin
					mon_q <= 4'd0;
				end
			end
			ST_MON: begin
				if (ge && mon_q != LastMonth) begin
					days_q <= diff[15:0];
					mon_q  <= mon_q + 4'd1;
				end else begin
					div_q <= HourDivInit;
					cnt_q <= 4'(HourQuoBits - 1);
					quo_q <= 16'd0;
				end
			end
			ST_HOUR: begin
				work_q <= work_next;
				if (cnt_q == 4'd0) begin
					hour_q <= quo_next[4:0];
					div_q  <= MinDivInit;
					cnt_q  <= 4'(MinQuoBits - 1);
					quo_q  <= 16'd0;
				end else begin
					quo_q <= quo_next;
					div_q <= div_q >> 1;
					cnt_q <= cnt_q - 4'd1;
				end
			end
			ST_MIN: begin
				work_q <= work_next;
				quo_q  <= quo_next;
				div_q  <= div_q >> 1;
				cnt_q  <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					res_year_q   <= year_q;
					res_month_q  <= mon_q + 4'd1;
					res_day_q    <= days_q[4:0] + 5'd1;
					res_hour_q   <= hour_q;
					res_minute_q <= quo_next[5:0];
					res_second_q <= work_next[5:0];
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign year         = res_year_q;
	assign month        = res_month_q;
	assign day_of_month = res_day_q;
	assign hour         = res_hour_q;
	assign minute       = res_minute_q;
	assign second       = res_second_q;

endmodule
